// File: rtl/assert_macros.svh
// Assertion macros shared by the RTL of the trade CSV record parser.
// Bodies compile away when SYNTH is defined; they expect clk and rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_RST(lbl, prop, msg)
`define ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// File: rtl/tcsv_pkg.sv
// Package for the trade CSV record parser: payload structs, character codes,
// field numbers, side-word match codes and decimal field limits. No dependencies.
package tcsv_pkg;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_input;
  } in_item_t;

  typedef struct packed {
    logic [31:0]        symbol;
    logic [63:0]        created_time;
    logic [63:0]        trade_number;
    logic [31:0]        price_mantissa;
    logic signed [7:0]  price_scale;
    logic [31:0]        quantity_mantissa;
    logic signed [7:0]  quantity_scale;
    logic [7:0]         side_code;
    logic               record_error;
  } out_item_t;

  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UC_A  = 8'h41;
  localparam logic [7:0] CH_LC_A  = 8'h61;
  localparam logic [7:0] CH_UC_B  = 8'h42;
  localparam logic [7:0] CH_LC_B  = 8'h62;
  localparam logic [7:0] CH_LC_S  = 8'h73;
  localparam logic [7:0] CH_LC_K  = 8'h6B;
  localparam logic [7:0] CH_LC_I  = 8'h69;
  localparam logic [7:0] CH_LC_D  = 8'h64;

  // field positions within a line
  localparam logic [2:0] FLD_SYMBOL = 3'd0;
  localparam logic [2:0] FLD_CTIME  = 3'd1;
  localparam logic [2:0] FLD_TRADE  = 3'd2;
  localparam logic [2:0] FLD_PMANT  = 3'd3;
  localparam logic [2:0] FLD_PEXP   = 3'd4;
  localparam logic [2:0] FLD_QMANT  = 3'd5;
  localparam logic [2:0] FLD_QEXP   = 3'd6;
  localparam logic [2:0] FLD_SIDE   = 3'd7;

  // side field matcher codes
  localparam logic [3:0] SIDE_EMPTY  = 4'd0;
  localparam logic [3:0] SIDE_A      = 4'd1;
  localparam logic [3:0] SIDE_AS     = 4'd2;
  localparam logic [3:0] SIDE_ASK    = 4'd3;
  localparam logic [3:0] SIDE_B      = 4'd4;
  localparam logic [3:0] SIDE_BI     = 4'd5;
  localparam logic [3:0] SIDE_BID    = 4'd6;
  localparam logic [3:0] SIDE_DIGITS = 4'd7;
  localparam logic [3:0] SIDE_CLOSED = 4'd9;

  localparam logic [7:0] SIDE_CODE_ASK = 8'd1;
  localparam logic [7:0] SIDE_CODE_BID = 8'd2;

  localparam int        ACC_W  = 64;
  localparam int        PROD_W = ACC_W + 4;

  // largest value a field's digit run may reach
  function automatic logic [PROD_W-1:0] field_limit(input logic [2:0] fld);
    logic [PROD_W-1:0] lim;
    case (fld) inside
      FLD_SYMBOL, FLD_PMANT, FLD_QMANT: lim = PROD_W'(64'h0000_0000_FFFF_FFFF);
      FLD_PEXP, FLD_QEXP:               lim = PROD_W'(128);
      default:                          lim = PROD_W'(64'hFFFF_FFFF_FFFF_FFFF);
    endcase
    return lim;
  endfunction

endpackage

// File: rtl/trade_csv_record_parser.sv
// Trade CSV record parser top level: byte-wide line parser with output register.
// Depends on tcsv_pkg and assert_macros.svh.
//
// Usage:
//   in channel (in_valid/in_ready/in_data) takes one text byte per item, with
//   end_of_input marking the last byte of a stream. out channel
//   (out_valid/out_ready/out_data) gives one binary trade record per
//   non-empty line, at the line feed or at end of input.
//   cfg channel (cfg_valid/cfg_ready/cfg_data) writes skip_header; it is
//   always ready and also sets header skipping for the current line to cfg_data.
//   Throughput is one byte per cycle while no record is stalled and cfg_valid
//   is low: the per-byte work (one 68-bit multiply-by-ten add and limit
//   compare) sits between the line state registers and the output register.
//   Latency: a record is valid in the cycle after its closing byte is taken.
//   When out_ready is low with a record held, in_ready drops until the record
//   is taken; in_ready follows out_ready combinationally and is low while
//   cfg_valid is high, so a config write never collides with an input item.
//   Synchronous reset clears the line state and out_valid, leaves out_data, and sets
//   skip_header to 1, so the first line after reset is dropped.
module trade_csv_record_parser (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic                  cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  tcsv_pkg::in_item_t    in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output tcsv_pkg::out_item_t   out_data
);
  import tcsv_pkg::*;

  // line state
  logic             skip_header;
  logic             header_pending;
  logic [2:0]       field_index;
  logic [ACC_W-1:0] digit_acc;
  logic             minus_seen;
  logic             digits_seen;
  logic [3:0]       side_state;
  logic             line_has_bytes;
  logic             line_error;

  // closed fields of the current line
  logic [31:0] held_symbol;
  logic [63:0] held_ctime;
  logic [63:0] held_trade;
  logic [31:0] held_pmant;
  logic [7:0]  held_pexp;
  logic [31:0] held_qmant;
  logic [7:0]  held_qexp;

  logic             header_pending_next;
  logic [2:0]       field_index_next;
  logic [ACC_W-1:0] digit_acc_next;
  logic             minus_seen_next;
  logic             digits_seen_next;
  logic [3:0]       side_state_next;
  logic             line_has_bytes_next;
  logic             line_error_next;

  logic              in_fire;
  logic              cfg_fire;
  logic              emit;
  logic              held_wr;
  logic [63:0]       held_val;
  out_item_t         rec;
  logic [7:0]        b;
  logic              eoi;
  logic              is_digit;
  logic [3:0]        digit_val;
  logic [PROD_W-1:0] prod;
  logic              over;
  logic              is_exp_field;

  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign in_ready  = (!out_valid || out_ready) && !cfg_valid;
  assign in_fire   = in_valid && in_ready;

  assign b            = in_data.text_byte;
  assign eoi          = in_data.end_of_input;
  assign is_digit     = (b >= CH_ZERO) && (b <= CH_NINE);
  assign digit_val    = 4'(b - CH_ZERO);
  assign is_exp_field = (field_index == FLD_PEXP) || (field_index == FLD_QEXP);
  // acc*10 + d, compared against the field limit
  assign prod = {1'b0, digit_acc, 3'b000} + {3'b000, digit_acc, 1'b0} + PROD_W'(digit_val);
  assign over = prod > field_limit(field_index);

  always_comb begin
    header_pending_next = header_pending;
    field_index_next    = field_index;
    digit_acc_next      = digit_acc;
    minus_seen_next     = minus_seen;
    digits_seen_next    = digits_seen;
    side_state_next     = side_state;
    line_has_bytes_next = line_has_bytes;
    line_error_next     = line_error;
    held_wr             = 1'b0;
    held_val            = digit_acc;
    emit                = 1'b0;
    rec                 = '0;

    // byte handling (line feed only closes)
    if (b != CH_LF && b != CH_CR && !header_pending) begin
      line_has_bytes_next = 1'b1;
      if (!(field_index == FLD_SIDE && side_state == SIDE_CLOSED)) begin
        if (b == CH_COMMA) begin
          if (field_index != FLD_SIDE) begin
            if (!digits_seen) line_error_next = 1'b1;
            if (is_exp_field) begin
              if (!minus_seen && digit_acc > 64'd127) line_error_next = 1'b1;
              held_val = minus_seen ? 64'(8'd0 - digit_acc[7:0]) : 64'(digit_acc[7:0]);
            end
            held_wr          = 1'b1;
            field_index_next = field_index + 3'd1;
            digit_acc_next   = '0;
            minus_seen_next  = 1'b0;
            digits_seen_next = 1'b0;
            side_state_next  = SIDE_EMPTY;
          end else begin
            if (side_state == SIDE_ASK) digit_acc_next = 64'(SIDE_CODE_ASK);
            else if (side_state == SIDE_BID) digit_acc_next = 64'(SIDE_CODE_BID);
            else if (side_state != SIDE_DIGITS) line_error_next = 1'b1;
            side_state_next = SIDE_CLOSED;
          end
        end else if (is_digit) begin
          if (field_index == FLD_SIDE && side_state != SIDE_EMPTY &&
              side_state != SIDE_DIGITS) begin
            line_error_next = 1'b1;
          end else begin
            if (field_index == FLD_SIDE) side_state_next = SIDE_DIGITS;
            if (over) line_error_next = 1'b1;
            else digit_acc_next = prod[ACC_W-1:0];
            digits_seen_next = 1'b1;
          end
        end else if (b == CH_MINUS && is_exp_field && !digits_seen && !minus_seen) begin
          minus_seen_next = 1'b1;
        end else if (field_index == FLD_SIDE) begin
          if (side_state == SIDE_EMPTY && (b == CH_UC_A || b == CH_LC_A))
            side_state_next = SIDE_A;
          else if (side_state == SIDE_A && b == CH_LC_S) side_state_next = SIDE_AS;
          else if (side_state == SIDE_AS && b == CH_LC_K) side_state_next = SIDE_ASK;
          else if (side_state == SIDE_EMPTY && (b == CH_UC_B || b == CH_LC_B))
            side_state_next = SIDE_B;
          else if (side_state == SIDE_B && b == CH_LC_I) side_state_next = SIDE_BI;
          else if (side_state == SIDE_BI && b == CH_LC_D) side_state_next = SIDE_BID;
          else line_error_next = 1'b1;
        end else begin
          line_error_next = 1'b1;
        end
      end
    end

    // line close
    if (b == CH_LF || eoi) begin
      if (header_pending_next) begin
        header_pending_next = 1'b0;
      end else if (line_has_bytes_next) begin
        if (field_index_next != FLD_SIDE) begin
          line_error_next = 1'b1;
        end else if (side_state_next != SIDE_CLOSED) begin
          if (side_state_next == SIDE_ASK) digit_acc_next = 64'(SIDE_CODE_ASK);
          else if (side_state_next == SIDE_BID) digit_acc_next = 64'(SIDE_CODE_BID);
          else if (side_state_next != SIDE_DIGITS) line_error_next = 1'b1;
        end
        emit = 1'b1;
        if (line_error_next) begin
          rec.record_error = 1'b1;
        end else begin
          rec.symbol            = held_symbol;
          rec.created_time      = held_ctime;
          rec.trade_number      = held_trade;
          rec.price_mantissa    = held_pmant;
          rec.price_scale       = held_pexp;
          rec.quantity_mantissa = held_qmant;
          rec.quantity_scale    = held_qexp;
          rec.side_code         = digit_acc_next[7:0];
        end
      end
      field_index_next    = FLD_SYMBOL;
      line_has_bytes_next = 1'b0;
      line_error_next     = 1'b0;
      digit_acc_next      = '0;
      minus_seen_next     = 1'b0;
      digits_seen_next    = 1'b0;
      side_state_next     = SIDE_EMPTY;
    end
    if (eoi) header_pending_next = skip_header;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      skip_header    <= 1'b1;
      header_pending <= 1'b1;
      field_index    <= FLD_SYMBOL;
      digit_acc      <= '0;
      minus_seen     <= 1'b0;
      digits_seen    <= 1'b0;
      side_state     <= SIDE_EMPTY;
      line_has_bytes <= 1'b0;
      line_error     <= 1'b0;
    end else if (cfg_fire) begin
      skip_header    <= cfg_data;
      header_pending <= cfg_data;
    end else if (in_fire) begin
      header_pending <= header_pending_next;
      field_index    <= field_index_next;
      digit_acc      <= digit_acc_next;
      minus_seen     <= minus_seen_next;
      digits_seen    <= digits_seen_next;
      side_state     <= side_state_next;
      line_has_bytes <= line_has_bytes_next;
      line_error     <= line_error_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && held_wr) begin
      case (field_index)
        FLD_SYMBOL: held_symbol <= held_val[31:0];
        FLD_CTIME:  held_ctime  <= held_val;
        FLD_TRADE:  held_trade  <= held_val;
        FLD_PMANT:  held_pmant  <= held_val[31:0];
        FLD_PEXP:   held_pexp   <= held_val[7:0];
        FLD_QMANT:  held_qmant  <= held_val[31:0];
        FLD_QEXP:   held_qexp   <= held_val[7:0];
        default: ;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire && emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && emit) out_data <= rec;
  end

`include "assert_macros.svh"

  `ASSERT_ALWAYS(a_reset_clears_out, $past(rst) |-> !out_valid, "record valid after reset")
  `ASSERT_RST(a_emit_on_close, in_fire && emit |-> (b == CH_LF || eoi),
              "record emitted without line feed or end of input")
  `ASSERT_RST(a_error_record_blank,
              out_valid && out_data.record_error |-> out_data.symbol == '0 &&
              out_data.trade_number == '0 && out_data.side_code == '0,
              "error record carries field data")
  `ASSERT_RST(a_no_overwrite, out_valid && !out_ready |-> !in_ready,
              "input taken while record stalled")

endmodule

// File: tb/trade_csv_record_parser_tb.sv
// Testbench for trade_csv_record_parser: directed and random CSV text with a
// line-level model that predicts each binary trade record.
// Depends on tcsv_pkg and the parser RTL only.
module trade_csv_record_parser_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tcsv_pkg::*;

  typedef logic [7:0] text_t[$];

  localparam int RANDOM_BYTES  = 200;
  localparam int SETTLE_CYCLES = 8;
  localparam int RX_HOLD       = 300;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  logic      cfg_data = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  trade_csv_record_parser dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  // line parser state as the block should hold it
  logic        p_skip, p_hdr, p_minus, p_digits, p_bytes, p_err;
  logic [2:0]  p_fld;
  logic [3:0]  p_side;
  logic [63:0] p_acc;
  logic [63:0] p_held[7];

  out_item_t records_due[$];
  int        bytes_sent = 0;
  int        mismatch_count = 0;
  bit        tx_idle_en = 1'b1;
  bit        rx_idle_en = 1'b1;
  bit        rx_hold_req = 1'b0;

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    #8_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic int pick_gap(bit enable);
    int r;
    r = $urandom_range(0, 99);
    if (!enable || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    if (r < 99) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // ---------------- line model ----------------

  function automatic logic [63:0] digit_cap(logic [2:0] f);
    case (f)
      FLD_SYMBOL, FLD_PMANT, FLD_QMANT: return 64'hFFFF_FFFF;
      FLD_PEXP, FLD_QEXP:               return 64'd128;
      default:                          return '1;
    endcase
  endfunction

  task automatic clear_field();
    p_acc = '0;
    p_minus = 1'b0;
    p_digits = 1'b0;
    p_side = SIDE_EMPTY;
  endtask

  task automatic clear_line();
    p_fld = FLD_SYMBOL;
    p_bytes = 1'b0;
    p_err = 1'b0;
    clear_field();
  endtask

  task automatic model_reset();
    p_skip = 1'b1;
    p_hdr = 1'b1;
    foreach (p_held[i]) p_held[i] = '0;
    clear_line();
  endtask

  task automatic push_digit(logic [7:0] b);
    logic [63:0] d, cap;
    d = 64'(b - CH_ZERO);
    cap = digit_cap(p_fld);
    if (p_acc > (cap - d) / 10) p_err = 1'b1;
    else p_acc = p_acc * 10 + d;
    p_digits = 1'b1;
  endtask

  task automatic close_number();
    logic [63:0] v;
    logic [7:0]  e;
    v = p_acc;
    if (!p_digits) p_err = 1'b1;
    if (p_fld == FLD_PEXP || p_fld == FLD_QEXP) begin
      if (!p_minus && v > 127) p_err = 1'b1;
      e = p_minus ? 8'(~v + 64'd1) : v[7:0];
      v = {56'd0, e};
    end
    p_held[p_fld] = v;
  endtask

  task automatic close_side_word();
    if (p_side == SIDE_ASK) p_acc = 64'(SIDE_CODE_ASK);
    else if (p_side == SIDE_BID) p_acc = 64'(SIDE_CODE_BID);
    else if (p_side != SIDE_DIGITS) p_err = 1'b1;
    p_side = SIDE_CLOSED;
  endtask

  task automatic side_letter(logic [7:0] b);
    logic [3:0] n;
    n = SIDE_EMPTY;
    if (p_side == SIDE_EMPTY && (b == CH_UC_A || b == CH_LC_A)) n = SIDE_A;
    else if (p_side == SIDE_A && b == CH_LC_S) n = SIDE_AS;
    else if (p_side == SIDE_AS && b == CH_LC_K) n = SIDE_ASK;
    else if (p_side == SIDE_EMPTY && (b == CH_UC_B || b == CH_LC_B)) n = SIDE_B;
    else if (p_side == SIDE_B && b == CH_LC_I) n = SIDE_BI;
    else if (p_side == SIDE_BI && b == CH_LC_D) n = SIDE_BID;
    if (n == SIDE_EMPTY) p_err = 1'b1;
    else p_side = n;
  endtask

  task automatic take_char(logic [7:0] b);
    if (b == CH_CR || p_hdr) return;
    p_bytes = 1'b1;
    // everything after the comma that ends the side field is dropped
    if (p_fld == FLD_SIDE && p_side == SIDE_CLOSED) return;
    if (b == CH_COMMA) begin
      if (p_fld != FLD_SIDE) begin
        close_number();
        p_fld = p_fld + 3'd1;
        clear_field();
      end else begin
        close_side_word();
      end
    end else if (b >= CH_ZERO && b <= CH_NINE) begin
      if (p_fld == FLD_SIDE) begin
        if (p_side == SIDE_EMPTY || p_side == SIDE_DIGITS) begin
          p_side = SIDE_DIGITS;
          push_digit(b);
        end else begin
          p_err = 1'b1;
        end
      end else begin
        push_digit(b);
      end
    end else if (b == CH_MINUS && (p_fld == FLD_PEXP || p_fld == FLD_QEXP) &&
                 !p_digits && !p_minus) begin
      p_minus = 1'b1;
    end else if (p_fld == FLD_SIDE) begin
      side_letter(b);
    end else begin
      p_err = 1'b1;
    end
  endtask

  task automatic close_record_line();
    out_item_t rec;
    if (p_hdr) begin
      p_hdr = 1'b0;
    end else if (p_bytes) begin
      if (p_fld != FLD_SIDE) p_err = 1'b1;
      else if (p_side != SIDE_CLOSED) close_side_word();
      rec = '0;
      if (p_err) begin
        rec.record_error = 1'b1;
      end else begin
        rec.symbol            = p_held[FLD_SYMBOL][31:0];
        rec.created_time      = p_held[FLD_CTIME];
        rec.trade_number      = p_held[FLD_TRADE];
        rec.price_mantissa    = p_held[FLD_PMANT][31:0];
        rec.price_scale       = p_held[FLD_PEXP][7:0];
        rec.quantity_mantissa = p_held[FLD_QMANT][31:0];
        rec.quantity_scale    = p_held[FLD_QEXP][7:0];
        rec.side_code         = p_acc[7:0];
      end
      records_due.push_back(rec);
    end
    clear_line();
  endtask

  task automatic parse_byte(logic [7:0] b, logic eoi);
    if (b == CH_LF) begin
      close_record_line();
    end else begin
      take_char(b);
      if (eoi) close_record_line();
    end
    if (eoi) p_hdr = p_skip;
  endtask

  // ---------------- checking ----------------

  task automatic flag_mismatch(string msg);
    if (mismatch_count < 40) $display("%0t: mismatch: %s", $realtime, msg);
    mismatch_count++;
  endtask

  task automatic check_record(out_item_t got, out_item_t want);
    if (got.symbol !== want.symbol)
      flag_mismatch($sformatf("symbol %0h, want %0h", got.symbol, want.symbol));
    if (got.created_time !== want.created_time)
      flag_mismatch($sformatf("created_time %0h, want %0h",
                              got.created_time, want.created_time));
    if (got.trade_number !== want.trade_number)
      flag_mismatch($sformatf("trade_number %0h, want %0h",
                              got.trade_number, want.trade_number));
    if (got.price_mantissa !== want.price_mantissa)
      flag_mismatch($sformatf("price_mantissa %0h, want %0h",
                              got.price_mantissa, want.price_mantissa));
    if (got.price_scale !== want.price_scale)
      flag_mismatch($sformatf("price_scale %0h, want %0h",
                              got.price_scale, want.price_scale));
    if (got.quantity_mantissa !== want.quantity_mantissa)
      flag_mismatch($sformatf("quantity_mantissa %0h, want %0h",
                              got.quantity_mantissa, want.quantity_mantissa));
    if (got.quantity_scale !== want.quantity_scale)
      flag_mismatch($sformatf("quantity_scale %0h, want %0h",
                              got.quantity_scale, want.quantity_scale));
    if (got.side_code !== want.side_code)
      flag_mismatch($sformatf("side_code %0h, want %0h", got.side_code, want.side_code));
    if (got.record_error !== want.record_error)
      flag_mismatch($sformatf("record_error %0b, want %0b",
                              got.record_error, want.record_error));
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (records_due.size() == 0) flag_mismatch("record with none expected");
      else check_record(out_data, records_due.pop_front());
    end
  end

  // receiver: random idle cycles, plus a long hold when asked
  initial begin
    int idle_left, hold_left;
    idle_left = 0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (rx_hold_req) begin
        hold_left = RX_HOLD;
        rx_hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (idle_left > 0) begin
        out_ready <= 1'b0;
        idle_left--;
      end else begin
        out_ready <= 1'b1;
        idle_left = pick_gap(rx_idle_en);
      end
    end
  end

  // ---------------- driving ----------------

  // called and returns at a falling edge; valid stays up between back-to-back items
  task automatic send_byte(logic [7:0] b, logic eoi);
    int gap;
    gap = pick_gap(tx_idle_en);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{text_byte: b, end_of_input: eoi};
    do @(posedge clk); while (!in_ready);
    parse_byte(b, eoi);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_bytes(text_t t, bit eoi_last);
    foreach (t[i]) send_byte(t[i], eoi_last && i == t.size() - 1);
  endtask

  function automatic text_t to_bytes(string s);
    text_t t;
    for (int i = 0; i < s.len(); i++) t.push_back(s[i]);
    return t;
  endfunction

  task automatic send_line(string s, bit eoi_last = 1'b0);
    send_bytes(to_bytes(s), eoi_last);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (records_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic cfg_write(logic v);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    p_skip = v;
    p_hdr = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // ---------------- random text ----------------

  function automatic string num_text(logic [2:0] f);
    int r;
    logic [63:0] v;
    string s;
    r = $urandom_range(0, 99);
    if (f == FLD_PEXP || f == FLD_QEXP) begin
      v = $urandom_range(0, (r < 92) ? 127 : 200);
      s = $sformatf("%0d", v);
      return $urandom_range(0, 1) ? {"-", s} : s;
    end
    if (r < 60) v = $urandom_range(0, 999);
    else if (r < 85) v = ({$urandom, $urandom} >> $urandom_range(0, 63)) & digit_cap(f);
    else if (r < 94) v = digit_cap(f) - $urandom_range(0, 9);
    else if (r < 97 && f != FLD_CTIME && f != FLD_TRADE) v = 64'h1_0000_0000 + r;
    else return {$sformatf("%0d", digit_cap(f)), "7"};
    s = $sformatf("%0d", v);
    return (r % 20 == 3) ? {"00", s} : s;
  endfunction

  function automatic string side_text();
    case ($urandom_range(0, 9))
      0: return "Ask";
      1: return "ask";
      2: return "Bid";
      3: return "bid";
      4: return $sformatf("%0d", $urandom_range(0, 300));
      5: return $sformatf("%0d", {$urandom, $urandom});
      6: return $urandom_range(0, 1) ? "1" : "2";
      7: return $urandom_range(0, 1) ? "As" : "bi";
      default: return $urandom_range(0, 1) ? "Ask" : "Bid";
    endcase
  endfunction

  function automatic string random_line();
    string s;
    s = "";
    for (int f = 0; f < 7; f++) s = {s, num_text(3'(f)), ","};
    s = {s, side_text()};
    if ($urandom_range(0, 9) == 0) s = {s, ",x9,-"};
    return s;
  endfunction

  function automatic void damage(ref text_t t);
    int pos;
    pos = $urandom_range(0, t.size() - 1);
    case ($urandom_range(0, 3))
      0: t = t[0:pos];
      1: t.insert(pos, 8'($urandom_range(0, 255)));
      2: t.delete(pos);
      default: t.insert(pos, CH_CR);
    endcase
  endfunction

  function automatic text_t noise_bytes();
    text_t t;
    repeat ($urandom_range(1, 6)) t.push_back(8'($urandom_range(0, 255)));
    return t;
  endfunction

  // ---------------- tests ----------------

  task automatic test_header_skip();
    send_line("symbol,created_time,trade_number,price,pexp,qty,qexp,side\n");
    send_line("1,2,3,4,-5,6,7,Ask\n");
  endtask

  task automatic test_field_extremes();
    send_line({"4294967295,18446744073709551615,18446744073709551615,4294967295,127,",
               "4294967295,-128,255\n"});
    send_line("0,0,0,0,0,0,-0,0\n");
    send_line("00042,10,20,30,-128,40,127,bid\n");
  endtask

  task automatic test_side_words();
    string words[$] = '{"Ask", "ask", "Bid", "bid", "1", "2", "300",
                        "18446744073709551615", "Ab", "ASK", "Bidd", "A1", "1A", ""};
    foreach (words[i]) send_line({"7,1,2,3,4,5,6,", words[i], "\n"});
  endtask

  task automatic test_overflow();
    string lines[$] = '{"4294967296,1,1,1,1,1,1,1", "1,18446744073709551616,1,1,1,1,1,1",
                        "1,1,99999999999999999999,1,1,1,1,1", "1,1,1,4294967296,1,1,1,1",
                        "1,1,1,1,128,1,1,1", "1,1,1,1,-129,1,1,1",
                        "1,1,1,1,1,4294967296,1,1", "1,1,1,1,1,1,200,1",
                        "1,1,1,1,1,1,1,18446744073709551616"};
    foreach (lines[i]) send_line({lines[i], "\n"});
  endtask

  task automatic test_empty_and_cr();
    send_line("\n");
    send_line("\r\n");
    send_line("\r\r\n");
    send_line("1\r,2,3\r,4,5,6,7,Bid\r\n");
  endtask

  task automatic test_missing_fields();
    send_line("1,2,3\n");
    send_line("1,,3,4,5,6,7,Ask\n");
    send_line("1,2,3,4,5,6,7\n");
    send_line("1,2,3,4,-,6,7,Ask\n");
  endtask

  task automatic test_stray_chars();
    text_t t;
    send_line("1x,2,3,4,5,6,7,Ask\n");
    send_line("1,2,3,4,--5,6,7,Ask\n");
    send_line("1,2,3,4,5-,6,7,Ask\n");
    send_line("1,-2,3,4,5,6,7,Ask\n");
    send_line("1,2,3,4,5,6,7, Ask\n");
    t = to_bytes("1,2,3,4,5,6,7,");
    t.push_back(8'hFF);
    t.push_back(CH_LF);
    send_bytes(t, 1'b0);
    t = to_bytes(",2,3,4,5,6,7,Bid\n");
    t.push_front(8'h00);
    send_bytes(t, 1'b0);
  endtask

  task automatic test_extra_fields();
    send_line("1,2,3,4,5,6,7,Bid,junk,x!\n");
    send_line("1,2,3,4,5,6,7,12,,\n");
  endtask

  task automatic test_end_of_input();
    // unterminated line closed by the last byte; header skip then re-arms
    send_line("1,2,3,4,5,6,7,Ask", 1'b1);
    send_line("\n");
    send_line("9,8,7,6,5,4,3,2\n", 1'b1);
    send_line("h,e,a,d\n");
    send_line("5,5,5,5,5,5,5,bi", 1'b1);
    send_line("\r", 1'b1);
  endtask

  task automatic test_config_writes();
    cfg_write(1'b0);
    send_line("1,2,3,4,5,6,7,Ask\n");
    send_line("3,3,3,3,3,3,3,3", 1'b1);
    send_line("4,4,4,4,4,4,4,4\n");
    cfg_write(1'b1);
    send_line("x\n");
    // a write in mid-line turns the rest of the line into the header
    send_line("5,6,");
    cfg_write(1'b1);
    send_line(",7,8,9,1,2,Ask\n");
    send_line("6,6,6,6,6,6,6,Bid\n");
    cfg_write(1'b0);
  endtask

  task automatic test_backpressure();
    bit tx_save;
    tx_save = tx_idle_en;
    tx_idle_en = 1'b0;
    rx_hold_req = 1'b1;
    repeat (3) send_line({random_line(), "\n"});
    tx_idle_en = tx_save;
    wait_drained();
  endtask

  task automatic test_random_lines();
    text_t t;
    int k, e, first_bytes;
    bit eoi_last;
    first_bytes = bytes_sent;
    while (bytes_sent - first_bytes < RANDOM_BYTES) begin
      if ($urandom_range(0, 29) == 0) begin
        tx_idle_en = ($urandom_range(0, 3) != 0);
        rx_idle_en = ($urandom_range(0, 3) != 0);
        cfg_write($urandom_range(0, 1));
      end
      k = $urandom_range(0, 99);
      t = to_bytes(random_line());
      if (k >= 75 && k < 90) damage(t);
      else if (k >= 90 && k < 95) t = noise_bytes();
      else if (k >= 95) t.delete();
      e = $urandom_range(0, 99);
      eoi_last = 1'b0;
      if (t.size() == 0 || e < 80) begin
        t.push_back(CH_LF);
      end else if (e < 88) begin
        t.push_back(CH_CR);
        t.push_back(CH_LF);
      end else if (e < 94) begin
        eoi_last = 1'b1;
      end else begin
        t.push_back(CH_LF);
        eoi_last = 1'b1;
      end
      send_bytes(t, eoi_last);
    end
  endtask

  initial begin
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    model_reset();
    test_header_skip();
    test_field_extremes();
    test_side_words();
    test_overflow();
    test_empty_and_cr();
    test_missing_fields();
    test_stray_chars();
    test_extra_fields();
    test_end_of_input();
    test_config_writes();
    test_backpressure();
    test_random_lines();
    wait_drained();
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+rtl
rtl/tcsv_pkg.sv
rtl/trade_csv_record_parser.sv
tb/trade_csv_record_parser_tb.sv
